// ===== src/ctd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ctd_pkg;

	// Field widths of one transaction
	localparam int LEN_W  = 13;
	localparam int CYC_W  = 31;
	localparam int IDX_W  = 12;
	localparam int DATA_W = 32;
	localparam int CLK_W  = 64;

	localparam logic [7:0] LEVEL_HIGH_BYTE = 8'h80;

	// Transaction kinds
	typedef enum logic [2:0] {
		KIND_ADVANCE    = 3'd0,
		KIND_READ_IN    = 3'd1,
		KIND_TOGGLE     = 3'd2,
		KIND_WRITE_TAPE = 3'd3,
		KIND_PLAY       = 3'd4,
		KIND_REWIND     = 3'd5,
		KIND_CLEAR_REC  = 3'd6,
		KIND_READ_REC   = 3'd7
	} kind_t;

	// Register indexes
	localparam logic REG_TAPE_LENGTH   = 1'b0;
	localparam logic REG_INITIAL_LEVEL = 1'b1;

	// Configuration in effect after the current edge, with a load strobe
	typedef struct packed {
		logic             load;
		logic [LEN_W-1:0] tape_length;
		logic             initial_level;
	} cfg_t;

endpackage

`default_nettype wire

// ===== src/cassette_tape_deck_timing_unit.sv =====
// Cassette deck timing unit.
// Transactions enter on the in channel (in_valid/in_ready) with kind,
// cycle_count, entry_index and entry_value; each one yields exactly one
// result on the out channel (out_valid/out_ready) carrying the level byte,
// recorded entry data and deck status after that transaction.
// Registers tape_length (0x0) and tape_initial_level (0x4) sit behind an
// APB-style port; a write to either rewinds the deck and holds in_ready low
// for that edge. Write them only while no transaction is outstanding.
// Sequencing: every kind but advance moves from idle to the done state, which
// loads the result once the output register is free. An advance loops through
// check, load and step states over the tape memory (one read, registered data):
// check finishes, fetches the next segment or keeps the current one; load takes
// the fetched segment; step ends inside it or crosses it and returns to check.
// One transaction is processed at a time; the next is accepted as soon as the
// sequencer is idle, even while the previous result waits in the output
// register. If the receiver stalls, the result holds and the following
// transaction completes internally and waits for the output register.
// Reset clears all deck state; both memories hold unknown data until written.
`timescale 1ns / 1ps
`default_nettype none

module cassette_tape_deck_timing_unit
	import ctd_pkg::*;
#(
	parameter int TAPE_DEPTH   = 4096,
	parameter int RECORD_DEPTH = 4096
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        kind,
	input  wire logic [CYC_W-1:0]  cycle_count,
	input  wire logic [IDX_W-1:0]  entry_index,
	input  wire logic [DATA_W-1:0] entry_value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             level_byte,
	output logic [DATA_W-1:0]      entry_data,
	output logic                   playing,
	output logic                   armed,
	output logic [LEN_W-1:0]       recorded_count,
	output logic                   recorded_start_level,
	output logic                   record_overflow
);

	localparam int TAW = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
	localparam int RAW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
	localparam int RFW = $clog2(RECORD_DEPTH + 1);

	cfg_t              cfg;
	logic              tape_we;
	logic [TAW-1:0]    tape_waddr;
	logic [DATA_W-1:0] tape_wdata;
	logic              tape_re;
	logic [TAW-1:0]    tape_raddr;
	logic [DATA_W-1:0] tape_rdata;
	logic              rec_we;
	logic [RAW-1:0]    rec_waddr;
	logic [DATA_W-1:0] rec_wdata;
	logic              rec_re;
	logic [RAW-1:0]    rec_raddr;
	logic [DATA_W-1:0] rec_rdata;

	ctd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ctd_ram #(
		.DEPTH (TAPE_DEPTH),
		.AW    (TAW),
		.DW    (DATA_W)
	) u_tape_ram (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.re    (tape_re),
		.raddr (tape_raddr),
		.rdata (tape_rdata)
	);

	ctd_ram #(
		.DEPTH (RECORD_DEPTH),
		.AW    (RAW),
		.DW    (DATA_W)
	) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.re    (rec_re),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	ctd_engine #(
		.TAPE_DEPTH   (TAPE_DEPTH),
		.RECORD_DEPTH (RECORD_DEPTH),
		.TAW          (TAW),
		.RAW          (RAW),
		.RFW          (RFW)
	) u_engine (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg                  (cfg),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.kind                 (kind),
		.cycle_count          (cycle_count),
		.entry_index          (entry_index),
		.entry_value          (entry_value),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.level_byte           (level_byte),
		.entry_data           (entry_data),
		.playing              (playing),
		.armed                (armed),
		.recorded_count       (recorded_count),
		.recorded_start_level (recorded_start_level),
		.record_overflow      (record_overflow),
		.tape_we              (tape_we),
		.tape_waddr           (tape_waddr),
		.tape_wdata           (tape_wdata),
		.tape_re              (tape_re),
		.tape_raddr           (tape_raddr),
		.tape_rdata           (tape_rdata),
		.rec_we               (rec_we),
		.rec_waddr            (rec_waddr),
		.rec_wdata            (rec_wdata),
		.rec_re               (rec_re),
		.rec_raddr            (rec_raddr),
		.rec_rdata            (rec_rdata)
	);

endmodule

`default_nettype wire

// ===== src/ctd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctd_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/ctd_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctd_cfg
	import ctd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [LEN_W-1:0] tape_length_q;
	logic             initial_level_q;
	logic             wr;
	logic             sel;

	assign sel    = paddr[2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	// Hold register contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tape_length_q   <= '0;
			initial_level_q <= 1'b0;
		end else if (wr) begin
			if (sel == REG_TAPE_LENGTH) begin
				tape_length_q <= pwdata[LEN_W-1:0];
			end else begin
				initial_level_q <= pwdata[0];
			end
		end
	end

	// Present the values that take effect at this edge
	always_comb begin
		cfg.load          = wr;
		cfg.tape_length   = (wr && sel == REG_TAPE_LENGTH) ? pwdata[LEN_W-1:0] : tape_length_q;
		cfg.initial_level = (wr && sel == REG_INITIAL_LEVEL) ? pwdata[0] : initial_level_q;
	end

	// Read back
	assign prdata = (sel == REG_INITIAL_LEVEL) ? {31'd0, initial_level_q}
	                                           : {{(32 - LEN_W){1'b0}}, tape_length_q};

endmodule

`default_nettype wire

// ===== src/ctd_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctd_engine
	import ctd_pkg::*;
#(
	parameter int TAPE_DEPTH   = 4096,
	parameter int RECORD_DEPTH = 4096,
	parameter int TAW          = 12,
	parameter int RAW          = 12,
	parameter int RFW          = 13
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        kind,
	input  wire logic [CYC_W-1:0]  cycle_count,
	input  wire logic [IDX_W-1:0]  entry_index,
	input  wire logic [DATA_W-1:0] entry_value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             level_byte,
	output logic [DATA_W-1:0]      entry_data,
	output logic                   playing,
	output logic                   armed,
	output logic [LEN_W-1:0]       recorded_count,
	output logic                   recorded_start_level,
	output logic                   record_overflow,
	output logic                   tape_we,
	output logic [TAW-1:0]         tape_waddr,
	output logic [DATA_W-1:0]      tape_wdata,
	output logic                   tape_re,
	output logic [TAW-1:0]         tape_raddr,
	input  wire logic [DATA_W-1:0] tape_rdata,
	output logic                   rec_we,
	output logic [RAW-1:0]         rec_waddr,
	output logic [DATA_W-1:0]      rec_wdata,
	output logic                   rec_re,
	output logic [RAW-1:0]         rec_raddr,
	input  wire logic [DATA_W-1:0] rec_rdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV_CHECK,
		ST_ADV_LOAD,
		ST_ADV_STEP,
		ST_DONE
	} state_t;

	localparam logic [RFW-1:0] REC_FULL = RFW'(RECORD_DEPTH);

	state_t              state_q;
	kind_t               kind_q;
	logic [CYC_W-1:0]    rem_q;
	logic                rec_hit_q;
	logic [CLK_W-1:0]    clock_q;
	logic [CLK_W-1:0]    last_toggle_q;
	logic                output_high_q;
	logic                start_high_q;
	logic [RFW-1:0]      fill_q;
	logic [LEN_W-1:0]    pos_q;
	logic [DATA_W-1:0]   seg_q;
	logic                input_high_q;
	logic                armed_q;
	logic                active_q;
	logic                overflow_q;

	logic                out_valid_q;
	logic [7:0]          level_byte_q;
	logic [DATA_W-1:0]   entry_data_q;
	logic                playing_q;
	logic                armed_out_q;
	logic [LEN_W-1:0]    recorded_count_q;
	logic                start_level_q;
	logic                overflow_out_q;

	logic                accept;
	logic [LEN_W-1:0]    eff_len;
	logic                rec_start;
	logic [CLK_W-1:0]    delta;
	logic                later;
	logic [DATA_W-1:0]   rec_dur;
	logic                rec_room;
	logic                rec_hit;
	logic                rem_lt_seg;
	logic [CYC_W-1:0]    rem_minus_seg;
	logic                tape_end;

	// Hold off transactions while a register write rewinds the deck
	assign in_ready = (state_q == ST_IDLE) && !cfg.load;
	assign accept   = in_valid && in_ready;

	// Effective tape length, saturated to the store depth
	assign eff_len = (32'(cfg.tape_length) > 32'(TAPE_DEPTH)) ? LEN_W'(TAPE_DEPTH)
	                                                          : cfg.tape_length;
	assign tape_end = (pos_q >= eff_len);

	// Tape store write
	assign tape_we    = accept && (kind_t'(kind) == KIND_WRITE_TAPE)
	                    && (32'(entry_index) < 32'(TAPE_DEPTH));
	assign tape_waddr = TAW'(entry_index);
	assign tape_wdata = (entry_value == '0) ? DATA_W'(1) : entry_value;

	// Tape store read at the play position
	assign tape_re    = (state_q == ST_ADV_CHECK);
	assign tape_raddr = TAW'(pos_q);

	// Duration since the previous toggle, saturated to 32 bits
	assign rec_start = (last_toggle_q == '0) && (fill_q == '0);
	assign delta     = clock_q - last_toggle_q;
	assign later     = (clock_q > last_toggle_q);
	assign rec_dur   = (delta[CLK_W-1:DATA_W] != '0) ? '1 : delta[DATA_W-1:0];
	assign rec_room  = (fill_q < REC_FULL);

	assign rec_we    = accept && (kind_t'(kind) == KIND_TOGGLE) && !rec_start && later
	                   && rec_room;
	assign rec_waddr = RAW'(fill_q);
	assign rec_wdata = rec_dur;

	// Record store read
	assign rec_re    = accept && (kind_t'(kind) == KIND_READ_REC);
	assign rec_raddr = RAW'(entry_index);
	assign rec_hit   = (32'(entry_index) < 32'(fill_q));

	// Segment arithmetic
	assign rem_lt_seg    = ({1'b0, rem_q} < seg_q);
	assign rem_minus_seg = rem_q - seg_q[CYC_W-1:0];

	// Sequence transactions and hold deck state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			kind_q           <= KIND_ADVANCE;
			rem_q            <= '0;
			rec_hit_q        <= 1'b0;
			clock_q          <= '0;
			last_toggle_q    <= '0;
			output_high_q    <= 1'b0;
			start_high_q     <= 1'b0;
			fill_q           <= '0;
			pos_q            <= '0;
			seg_q            <= '0;
			input_high_q     <= 1'b0;
			armed_q          <= 1'b0;
			active_q         <= 1'b0;
			overflow_q       <= 1'b0;
			out_valid_q      <= 1'b0;
			level_byte_q     <= '0;
			entry_data_q     <= '0;
			playing_q        <= 1'b0;
			armed_out_q      <= 1'b0;
			recorded_count_q <= '0;
			start_level_q    <= 1'b0;
			overflow_out_q   <= 1'b0;
		end else begin
			// Drop a taken result unless the next one is loaded at this edge
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cfg.load) begin
						// Tape load: stop and rewind
						armed_q      <= (eff_len != '0);
						active_q     <= 1'b0;
						pos_q        <= '0;
						seg_q        <= '0;
						input_high_q <= cfg.initial_level;
					end else if (accept) begin
						kind_q  <= kind_t'(kind);
						state_q <= ST_DONE;
						unique case (kind_t'(kind))
							KIND_ADVANCE: begin
								clock_q <= clock_q + CLK_W'(cycle_count);
								rem_q   <= cycle_count;
								state_q <= ST_ADV_CHECK;
							end
							KIND_READ_IN: begin
								if (armed_q) begin
									armed_q      <= 1'b0;
									active_q     <= (eff_len != '0);
									pos_q        <= '0;
									seg_q        <= '0;
									input_high_q <= cfg.initial_level;
								end
							end
							KIND_TOGGLE: begin
								if (rec_start) begin
									start_high_q <= output_high_q;
								end else if (later) begin
									if (rec_room) begin
										fill_q <= fill_q + RFW'(1);
									end else begin
										overflow_q <= 1'b1;
									end
								end
								last_toggle_q <= clock_q;
								output_high_q <= !output_high_q;
							end
							KIND_WRITE_TAPE: begin
								// store write happens in the tape memory
							end
							KIND_PLAY: begin
								if (eff_len != '0) begin
									armed_q      <= 1'b0;
									active_q     <= 1'b1;
									pos_q        <= '0;
									seg_q        <= '0;
									input_high_q <= cfg.initial_level;
								end
							end
							KIND_REWIND: begin
								armed_q      <= (eff_len != '0);
								active_q     <= 1'b0;
								pos_q        <= '0;
								seg_q        <= '0;
								input_high_q <= cfg.initial_level;
							end
							KIND_CLEAR_REC: begin
								fill_q        <= '0;
								start_high_q  <= output_high_q;
								last_toggle_q <= '0;
								overflow_q    <= 1'b0;
							end
							KIND_READ_REC: begin
								rec_hit_q <= rec_hit;
							end
							default: begin
							end
						endcase
					end
				end

				ST_ADV_CHECK: begin
					// Finish, fetch the next segment or consume the current one
					if (rem_q == '0 || !active_q) begin
						state_q <= ST_DONE;
					end else if (seg_q == '0) begin
						if (tape_end) begin
							active_q <= 1'b0;
							state_q  <= ST_DONE;
						end else begin
							pos_q   <= pos_q + LEN_W'(1);
							state_q <= ST_ADV_LOAD;
						end
					end else begin
						state_q <= ST_ADV_STEP;
					end
				end

				ST_ADV_LOAD: begin
					seg_q   <= (tape_rdata == '0) ? DATA_W'(1) : tape_rdata;
					state_q <= ST_ADV_STEP;
				end

				ST_ADV_STEP: begin
					if (rem_lt_seg) begin
						seg_q   <= seg_q - DATA_W'(rem_q);
						rem_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						// Cross the boundary: flip the level
						rem_q        <= rem_minus_seg;
						seg_q        <= '0;
						input_high_q <= !input_high_q;
						if (tape_end) begin
							active_q <= 1'b0;
						end
						state_q <= ST_ADV_CHECK;
					end
				end

				ST_DONE: begin
					// Load the result once the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						priority if (kind_q == KIND_READ_IN) begin
							level_byte_q <= input_high_q ? LEVEL_HIGH_BYTE : 8'h00;
						end else if (kind_q == KIND_TOGGLE) begin
							level_byte_q <= output_high_q ? LEVEL_HIGH_BYTE : 8'h00;
						end else begin
							level_byte_q <= 8'h00;
						end
						entry_data_q     <= (kind_q == KIND_READ_REC && rec_hit_q) ? rec_rdata
						                                                           : '0;
						playing_q        <= active_q;
						armed_out_q      <= armed_q;
						recorded_count_q <= LEN_W'(fill_q);
						start_level_q    <= start_high_q;
						overflow_out_q   <= overflow_q;
						state_q          <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid            = out_valid_q;
	assign level_byte           = level_byte_q;
	assign entry_data           = entry_data_q;
	assign playing              = playing_q;
	assign armed                = armed_out_q;
	assign recorded_count       = recorded_count_q;
	assign recorded_start_level = start_level_q;
	assign record_overflow      = overflow_out_q;

endmodule

`default_nettype wire

// ===== src/ctd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctd_checker
	import ctd_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [7:0]        level_byte,
	input wire logic [DATA_W-1:0] entry_data,
	input wire logic              playing,
	input wire logic              armed,
	input wire logic [LEN_W-1:0]  recorded_count,
	input wire logic              record_overflow
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level_byte) && $stable(entry_data))
		else $error("result changed while stalled");

	// Level byte is either low or high
	a_level_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level_byte == 8'h00 || level_byte == LEVEL_HIGH_BYTE))
		else $error("level byte neither 0x00 nor 0x80");

	// Playback cannot be running and waiting for the first read at once
	a_play_armed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(playing && armed))
		else $error("playing and armed both set");

	// A dropped entry implies the record store holds entries
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_overflow |-> recorded_count != '0)
		else $error("overflow flagged with an empty record store");

endmodule

bind cassette_tape_deck_timing_unit ctd_checker u_ctd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.level_byte      (level_byte),
	.entry_data      (entry_data),
	.playing         (playing),
	.armed           (armed),
	.recorded_count  (recorded_count),
	.record_overflow (record_overflow)
);

`default_nettype wire

// ===== verif/deck_timing_checker.sv =====
`timescale 1ns / 1ps

module deck_timing_checker
	import ctd_pkg::*;
#(
	parameter int TAPE_DEPTH   = 4096,
	parameter int RECORD_DEPTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [2:0]        kind,
	input  logic [CYC_W-1:0]  cycle_count,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [DATA_W-1:0] entry_value,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [7:0]        level_byte,
	input  logic [DATA_W-1:0] entry_data,
	input  logic              playing,
	input  logic              armed,
	input  logic [LEN_W-1:0]  recorded_count,
	input  logic              recorded_start_level,
	input  logic              record_overflow,
	output int                mismatch_count,
	output int                replies_owed
);

	localparam int AWAIT_DEPTH = 16;

	typedef struct packed {
		logic [7:0]        level_byte;
		logic [DATA_W-1:0] entry_data;
		logic              playing;
		logic              armed;
		logic [LEN_W-1:0]  recorded_count;
		logic              start_level;
		logic              overflow;
	} deck_status_t;

	// Mirror of the deck: both stores, time base, playback and recording state
	logic [DATA_W-1:0] tape_mem [0:TAPE_DEPTH-1];
	logic [DATA_W-1:0] rec_mem  [0:RECORD_DEPTH-1];
	logic [CLK_W-1:0]  cycle_clock;
	logic [CLK_W-1:0]  last_toggle;
	logic              out_high;
	logic              rec_start_high;
	logic [LEN_W-1:0]  rec_fill;
	logic [LEN_W-1:0]  play_pos;
	logic [DATA_W-1:0] seg_left;
	logic              in_high;
	logic              armed_q;
	logic              active_q;
	logic              ovf_q;
	logic [LEN_W-1:0]  cfg_len;
	logic              cfg_level;

	// Ring of predicted results in acceptance order
	deck_status_t awaited_status [0:AWAIT_DEPTH-1];
	int           awaited_rd;
	int           awaited_wr;
	int           awaited_cnt;
	deck_status_t want;
	deck_status_t got;

	function automatic logic [LEN_W-1:0] tape_span();
		return (cfg_len > TAPE_DEPTH) ? LEN_W'(TAPE_DEPTH) : cfg_len;
	endfunction

	task automatic restart_tape();
		play_pos = '0;
		seg_left = '0;
		in_high  = cfg_level;
	endtask

	task automatic rewind_deck();
		armed_q  = (tape_span() != 0);
		active_q = 1'b0;
		restart_tape();
	endtask

	// Consume elapsed cycles segment by segment, flipping the level at each boundary
	task automatic walk_tape(input logic [CLK_W-1:0] cycles);
		logic [LEN_W-1:0]  len;
		logic [CLK_W-1:0]  rem;
		logic [DATA_W-1:0] dur;
		len = tape_span();
		rem = cycles;
		if (!active_q || len == 0 || cycles == 0)
			return;
		while (rem > 0 && active_q) begin
			if (seg_left == 0) begin
				if (play_pos >= len) begin
					active_q = 1'b0;
					break;
				end
				dur = tape_mem[play_pos];
				seg_left = (dur == 0) ? 32'd1 : dur;
				play_pos++;
			end
			if (rem < seg_left) begin
				seg_left -= rem[DATA_W-1:0];
				break;
			end
			rem -= seg_left;
			seg_left = '0;
			in_high = ~in_high;
			if (play_pos >= len)
				active_q = 1'b0;
		end
	endtask

	// Flip the output level and log the time since the last flip
	task automatic toggle_output();
		logic [CLK_W-1:0] delta;
		if (last_toggle == 0 && rec_fill == 0) begin
			rec_start_high = out_high;
			last_toggle = cycle_clock;
		end
		if (cycle_clock > last_toggle) begin
			delta = cycle_clock - last_toggle;
			if (rec_fill < RECORD_DEPTH) begin
				rec_mem[rec_fill] = (delta > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : delta[DATA_W-1:0];
				rec_fill++;
			end else begin
				ovf_q = 1'b1;
			end
		end
		last_toggle = cycle_clock;
		out_high = ~out_high;
	endtask

	task automatic run_deck_command(input kind_t k, input logic [CYC_W-1:0] cyc,
			input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val,
			output deck_status_t st);
		st = '0;
		case (k)
			KIND_ADVANCE: begin
				if (cyc != 0) begin
					walk_tape({{(CLK_W-CYC_W){1'b0}}, cyc});
					cycle_clock += {{(CLK_W-CYC_W){1'b0}}, cyc};
				end
			end
			KIND_READ_IN: begin
				if (armed_q) begin
					armed_q  = 1'b0;
					active_q = (tape_span() != 0);
					restart_tape();
				end
				st.level_byte = in_high ? LEVEL_HIGH_BYTE : 8'h00;
			end
			KIND_TOGGLE: begin
				toggle_output();
				st.level_byte = out_high ? LEVEL_HIGH_BYTE : 8'h00;
			end
			KIND_WRITE_TAPE: begin
				if (idx < TAPE_DEPTH)
					tape_mem[idx] = (val == 0) ? 32'd1 : val;
			end
			KIND_PLAY: begin
				if (tape_span() != 0) begin
					armed_q  = 1'b0;
					active_q = 1'b1;
					restart_tape();
				end
			end
			KIND_REWIND: rewind_deck();
			KIND_CLEAR_REC: begin
				rec_fill       = '0;
				rec_start_high = out_high;
				last_toggle    = '0;
				ovf_q          = 1'b0;
			end
			default: begin
				if (idx < rec_fill && idx < RECORD_DEPTH)
					st.entry_data = rec_mem[idx];
			end
		endcase
		st.playing        = active_q;
		st.armed          = armed_q;
		st.recorded_count = rec_fill;
		st.start_level    = rec_start_high;
		st.overflow       = ovf_q;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// Track register writes, predict each accepted transaction, compare each result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_clock    = '0;
			last_toggle    = '0;
			out_high       = 1'b0;
			rec_start_high = 1'b0;
			rec_fill       = '0;
			ovf_q          = 1'b0;
			cfg_len        = '0;
			cfg_level      = 1'b0;
			rewind_deck();
			awaited_rd     = 0;
			awaited_wr     = 0;
			awaited_cnt    = 0;
			mismatch_count = 0;
			replies_owed <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_TAPE_LENGTH, 2'b00}) begin
					cfg_len = pwdata[LEN_W-1:0];
					rewind_deck();
				end else if (paddr == {REG_INITIAL_LEVEL, 2'b00}) begin
					cfg_level = pwdata[0];
					rewind_deck();
				end
			end
			if (out_valid && out_ready) begin
				if (awaited_cnt == 0) begin
					$display("%0t: result with no transaction outstanding, got level 0x%0h data 0x%0h",
						$time, level_byte, entry_data);
					mismatch_count++;
				end else begin
					want = awaited_status[awaited_rd];
					awaited_rd = (awaited_rd + 1) % AWAIT_DEPTH;
					awaited_cnt--;
					got  = {level_byte, entry_data, playing, armed, recorded_count,
						recorded_start_level, record_overflow};
					check_field("level_byte", want.level_byte, got.level_byte);
					check_field("entry_data", want.entry_data, got.entry_data);
					check_field("playing", want.playing, got.playing);
					check_field("armed", want.armed, got.armed);
					check_field("recorded_count", want.recorded_count, got.recorded_count);
					check_field("recorded_start_level", want.start_level, got.start_level);
					check_field("record_overflow", want.overflow, got.overflow);
				end
			end
			if (in_valid && in_ready) begin
				run_deck_command(kind_t'(kind), cycle_count, entry_index, entry_value, want);
				if (awaited_cnt == AWAIT_DEPTH) begin
					$display("%0t: too many transactions outstanding, expected at most %0d, got %0d",
						$time, AWAIT_DEPTH, awaited_cnt + 1);
					mismatch_count++;
				end else begin
					awaited_status[awaited_wr] = want;
					awaited_wr = (awaited_wr + 1) % AWAIT_DEPTH;
					awaited_cnt++;
				end
			end
			replies_owed <= awaited_cnt;
		end
	end

endmodule

// ===== verif/tb_cassette_tape_deck_timing_unit.sv =====
`timescale 1ns / 1ps

module tb_cassette_tape_deck_timing_unit;
	import ctd_pkg::*;

	localparam int TAPE_DEPTH   = 4096;
	localparam int RECORD_DEPTH = 4096;
	// Tape entries loaded at the start; playback never runs past them
	localparam int PREFILL      = 256;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [2:0]        kind;
	logic [CYC_W-1:0]  cycle_count;
	logic [IDX_W-1:0]  entry_index;
	logic [DATA_W-1:0] entry_value;
	logic              out_valid;
	logic              out_ready;
	logic [7:0]        level_byte;
	logic [DATA_W-1:0] entry_data;
	logic              playing;
	logic              armed;
	logic [LEN_W-1:0]  recorded_count;
	logic              recorded_start_level;
	logic              record_overflow;
	int                mismatch_count;
	int                replies_owed;

	bit               gaps_on = 1'b1;
	bit               short_adv;
	int unsigned      rec_guess;
	logic [LEN_W-1:0] cur_span;

	cassette_tape_deck_timing_unit #(
		.TAPE_DEPTH(TAPE_DEPTH),
		.RECORD_DEPTH(RECORD_DEPTH)
	) uut (.*);

	deck_timing_checker #(
		.TAPE_DEPTH(TAPE_DEPTH),
		.RECORD_DEPTH(RECORD_DEPTH)
	) checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#60_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// After each taken result, stall the result side at random while gaps are on
	initial begin : result_side
		int unsigned hold;
		hold = 0;
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (out_ready && out_valid) begin
				hold = gaps_on ? $urandom_range(0, 7) : 0;
				if (hold != 0)
					out_ready <= 1'b0;
			end else if (!out_ready) begin
				hold--;
				if (hold == 0)
					out_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input kind_t k, input logic [CYC_W-1:0] cyc,
			input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		int unsigned gap;
		gap = gaps_on ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		cycle_count <= cyc;
		entry_index <= idx;
		entry_value <= val;
		do @(posedge clk); while (!in_ready);
		if (k == KIND_TOGGLE && rec_guess < RECORD_DEPTH - 1)
			rec_guess++;
		if (k == KIND_CLEAR_REC)
			rec_guess = 0;
	endtask

	// Send a transaction of the given kind with every other field random
	task automatic send_kind(input kind_t k);
		send_item(k, CYC_W'($urandom), IDX_W'($urandom), $urandom);
	endtask

	// Hold off the sender until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (replies_owed != 0);
	endtask

	task automatic write_reg(input logic which, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {which, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_tape(input logic [LEN_W-1:0] len, input logic lvl);
		drain();
		write_reg(REG_TAPE_LENGTH, {{(32-LEN_W){1'b0}}, len});
		write_reg(REG_INITIAL_LEVEL, {31'b0, lvl});
		cur_span  = (len > TAPE_DEPTH) ? LEN_W'(TAPE_DEPTH) : len;
		short_adv = (cur_span > PREFILL);
	endtask

	// Weighted towards advances and reads so that playback gets somewhere
	task automatic random_item();
		int unsigned       pick;
		logic [CYC_W-1:0]  cyc;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] val;
		pick = $urandom_range(0, 99);
		cyc  = CYC_W'($urandom);
		idx  = IDX_W'($urandom);
		val  = $urandom;
		if (pick < 35) begin
			pick = $urandom_range(0, 99);
			// Keep playback on a long tape inside the loaded entries
			if (pick < 5)
				cyc = '0;
			else if (short_adv)
				cyc = CYC_W'($urandom_range(1, 3));
			else if (pick < 70)
				cyc = CYC_W'($urandom_range(1, 64));
			else if (pick < 92)
				cyc = CYC_W'($urandom_range(65, 5000));
			else if (pick < 97)
				cyc = CYC_W'($urandom_range(5001, 200000));
			send_item(KIND_ADVANCE, cyc, idx, val);
		end else if (pick < 50) begin
			send_item(KIND_READ_IN, cyc, idx, val);
		end else if (pick < 65) begin
			send_item(KIND_TOGGLE, cyc, idx, val);
		end else if (pick < 73) begin
			if (cur_span != 0 && $urandom_range(0, 1) != 0) begin
				idx = IDX_W'($urandom_range(0, int'(cur_span) - 1));
				val = $urandom_range(0, 40);
			end else if ($urandom_range(0, 9) < 7) begin
				val = $urandom_range(0, 40);
			end
			send_item(KIND_WRITE_TAPE, cyc, idx, val);
		end else if (pick < 80) begin
			send_item(KIND_PLAY, cyc, idx, val);
		end else if (pick < 84) begin
			send_item(KIND_REWIND, cyc, idx, val);
		end else if (pick < 88) begin
			send_item(KIND_CLEAR_REC, cyc, idx, val);
		end else begin
			if ($urandom_range(0, 4) != 0)
				idx = IDX_W'($urandom_range(0, rec_guess));
			send_item(KIND_READ_REC, cyc, idx, val);
		end
	endtask

	initial begin : stimulus
		int                i;
		int                p;
		int unsigned       pick;
		logic [LEN_W-1:0]  len;
		logic              lvl;
		logic [DATA_W-1:0] val;

		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		in_valid    <= 1'b0;
		kind        <= KIND_ADVANCE;
		cycle_count <= '0;
		entry_index <= '0;
		entry_value <= '0;
		rec_guess = 0;
		cur_span  = '0;
		short_adv = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load the leading tape entries that playback is allowed to reach
		load_tape('0, 1'b0);
		for (i = 0; i < PREFILL; i++) begin
			pick = $urandom_range(0, 99);
			val  = (pick < 70) ? $urandom_range(1, 20) :
			       (pick < 90) ? $urandom_range(21, 500) :
			       (pick < 99) ? 32'd0 : $urandom;
			send_item(KIND_WRITE_TAPE, CYC_W'($urandom), IDX_W'(i), val);
		end

		// Directed: recording at time zero, saturation, arming, end of tape
		load_tape(LEN_W'(3), 1'b1);
		send_kind(KIND_TOGGLE);
		send_item(KIND_READ_REC, CYC_W'($urandom), '0, $urandom);
		send_item(KIND_ADVANCE, '0, IDX_W'($urandom), $urandom);
		repeat (3) send_item(KIND_ADVANCE, '1, IDX_W'($urandom), $urandom);
		send_kind(KIND_TOGGLE);
		send_item(KIND_READ_REC, CYC_W'($urandom), '0, $urandom);
		send_item(KIND_READ_REC, CYC_W'($urandom), '1, $urandom);
		send_item(KIND_WRITE_TAPE, CYC_W'($urandom), '0, '0);
		send_item(KIND_WRITE_TAPE, CYC_W'($urandom), IDX_W'(1), 32'd3);
		send_item(KIND_WRITE_TAPE, CYC_W'($urandom), IDX_W'(2), 32'd2);
		send_item(KIND_WRITE_TAPE, CYC_W'($urandom), '1, '1);
		send_kind(KIND_READ_IN);
		send_item(KIND_ADVANCE, CYC_W'(1), IDX_W'($urandom), $urandom);
		send_item(KIND_ADVANCE, CYC_W'(5), IDX_W'($urandom), $urandom);
		send_kind(KIND_READ_IN);
		send_kind(KIND_PLAY);
		send_item(KIND_ADVANCE, '1, IDX_W'($urandom), $urandom);
		send_kind(KIND_READ_IN);
		send_kind(KIND_REWIND);
		send_kind(KIND_READ_IN);
		send_kind(KIND_CLEAR_REC);
		repeat (2) send_kind(KIND_TOGGLE);

		// Random phases over a spread of tape settings, extremes included
		for (p = 0; p < 8; p++) begin
			case (p)
				0: begin len = '0; lvl = 1'b1; end
				1: begin len = LEN_W'(1); lvl = 1'b0; end
				2: begin len = LEN_W'(TAPE_DEPTH); lvl = 1'b1; end
				3: begin len = '1; lvl = 1'b0; end
				4: begin len = LEN_W'(2); lvl = 1'b1; end
				5: begin len = LEN_W'($urandom_range(1, 16)); lvl = ($urandom_range(0, 1) != 0); end
				6: begin len = LEN_W'($urandom_range(1, 64)); lvl = ($urandom_range(0, 1) != 0); end
				default: begin
					len = LEN_W'($urandom_range(1, 300));
					lvl = ($urandom_range(0, 1) != 0);
				end
			endcase
			load_tape(len, lvl);
			for (i = 0; i < 50; i++) begin
				if (i % 25 == 0)
					gaps_on = ($urandom_range(0, 3) != 0);
				random_item();
			end
		end

		// Read back the recording, then clear it
		gaps_on = 1'b1;
		load_tape(LEN_W'(2), 1'b1);
		send_item(KIND_READ_REC, CYC_W'($urandom), '0, $urandom);
		send_item(KIND_READ_REC, CYC_W'($urandom), '1, $urandom);
		repeat (4) send_kind(KIND_READ_REC);
		send_kind(KIND_CLEAR_REC);
		send_item(KIND_READ_REC, CYC_W'($urandom), '0, $urandom);
		send_kind(KIND_TOGGLE);

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && replies_owed == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
